/* src/assert_macros.svh */
// Assertion helpers shared by the counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked property that also holds during reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/dbc_pkg.sv */
`timescale 1ns / 1ps
package dbc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 72;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegCountEnable = 3'd0;
  localparam logic [CfgIdxW-1:0] RegEdgeMode    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDebounceOn  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDebounceMs  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWidthSelect = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCountDown   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegStartValue  = 3'd6;

  // Edge modes
  localparam logic [1:0] EdgeRising  = 2'd0;
  localparam logic [1:0] EdgeFalling = 2'd1;
  localparam logic [1:0] EdgeBoth    = 2'd2;

  // Counter widths
  localparam logic [1:0] Width8  = 2'd0;
  localparam logic [1:0] Width16 = 2'd1;
  localparam logic [1:0] Width32 = 2'd2;

  typedef struct packed {
    logic              count_enable;
    logic [1:0]        edge_mode;
    logic              debounce_on;
    logic [TimeW-1:0]  debounce_ms;
    logic [1:0]        width_select;
    logic              count_down;
    logic [CountW-1:0] start_value;
  } cfg_t;

  typedef struct packed {
    logic              edge_counted;
    logic              wrapped;
    logic [CountW-1:0] count;
    logic              overflow_sticky;
  } result_t;

  function automatic logic [CountW-1:0] width_max(input logic [1:0] sel);
    logic [CountW-1:0] m;
    case (sel)
      Width8:  m = 64'h0000_0000_0000_00FF;
      Width16: m = 64'h0000_0000_0000_FFFF;
      Width32: m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

/* src/dbc_cfg_regs.sv */
`timescale 1ns / 1ps
module dbc_cfg_regs import dbc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{count_enable: 1'b0, edge_mode: EdgeRising, debounce_on: 1'b0,
                 debounce_ms: '0, width_select: Width32, count_down: 1'b0,
                 start_value: '0};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCountEnable: cfg_q.count_enable <= cfg_wdata_i[0];
        RegEdgeMode:    cfg_q.edge_mode    <= cfg_wdata_i[1:0];
        RegDebounceOn:  cfg_q.debounce_on  <= cfg_wdata_i[0];
        RegDebounceMs:  cfg_q.debounce_ms  <= cfg_wdata_i[TimeW-1:0];
        RegWidthSelect: cfg_q.width_select <= cfg_wdata_i[1:0];
        RegCountDown:   cfg_q.count_down   <= cfg_wdata_i[0];
        RegStartValue:  cfg_q.start_value  <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/dbc_update.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dbc_update import dbc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             step_i,
  input  logic             level_i,
  input  logic [TimeW-1:0] time_i,
  output result_t          res_o
);

  logic              level_q, level_d;
  logic [TimeW-1:0]  edge_time_q, edge_time_d;
  logic [CountW-1:0] count_q, count_d;
  logic              wrap_q, wrap_d;

  logic              edge_hit;
  logic              reject;
  logic              counted;
  logic              wrap_now;
  logic [TimeW-1:0]  dt;
  logic [CountW-1:0] maxv;
  logic [CountW-1:0] next_count;

  always_comb begin
    case (cfg_i.edge_mode)
      EdgeRising:  edge_hit = !level_q && level_i;
      EdgeFalling: edge_hit = level_q && !level_i;
      EdgeBoth:    edge_hit = level_q != level_i;
      default:     edge_hit = 1'b0;
    endcase
  end

  // Wrapping time since the last accepted edge
  assign dt      = time_i - edge_time_q;
  assign reject  = cfg_i.debounce_on && (cfg_i.debounce_ms != '0) && (dt < cfg_i.debounce_ms);
  assign counted = cfg_i.count_enable && edge_hit && !reject;
  assign maxv    = width_max(cfg_i.width_select);

  always_comb begin
    if (cfg_i.count_down) begin
      wrap_now   = counted && (count_q == '0);
      next_count = count_q - 64'd1;
    end else begin
      wrap_now   = counted && (count_q >= maxv);
      next_count = count_q + 64'd1;
    end
    if (wrap_now) begin
      next_count = cfg_i.start_value & maxv;
    end
  end

  always_comb begin
    level_d     = level_q;
    edge_time_d = edge_time_q;
    count_d     = count_q;
    wrap_d      = wrap_q | wrap_now;
    if (cfg_i.count_enable) begin
      level_d = level_i;
    end
    if (counted) begin
      edge_time_d = time_i;
      count_d     = next_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= 1'b0;
      edge_time_q <= '0;
      count_q     <= '0;
      wrap_q      <= 1'b0;
    end else if (step_i) begin
      level_q     <= level_d;
      edge_time_q <= edge_time_d;
      count_q     <= count_d;
      wrap_q      <= wrap_d;
    end
  end

  assign res_o.edge_counted    = counted;
  assign res_o.wrapped         = wrap_now;
  assign res_o.count           = counted ? next_count : count_q;
  assign res_o.overflow_sticky = wrap_d;

  `ASSERT_CLK(a_sticky_holds, clk_i, rst_ni, wrap_q |=> wrap_q, "sticky flag cleared")
  `ASSERT_CLK(a_idle_count, clk_i, rst_ni,
              (step_i && !counted) |=> (count_q == $past(count_q)), "count moved without edge")

endmodule

/* src/debounced_edge_updown_counter_core.sv */
`timescale 1ns / 1ps
// Debounced up/down edge counter, one channel.
//
// Input stream (s_axis): one word per pin sample, carrying the pin level and
// its millisecond timestamp. Output stream (m_axis): exactly one word per
// sample with the counted/wrapped flags, the counter value after the sample
// and the sticky overflow flag.
// Configuration: cfg_we_i writes register cfg_idx_i with cfg_wdata_i at the
// clock edge; write only while no sample is in flight.
// Path: input register, then output register driving m_axis. Throughput: one
// sample per cycle while m_axis is not stalled. The sample sits in the input
// register; edge detection, debounce compare and the 64-bit count step form one
// combinational pass into the output register, with the channel state updated
// on the same edge, so the next sample sees it at once.
// Stall: when m_axis_tready_i is low the output word holds; one more sample
// is absorbed in the input register, then s_axis_tready_o drops.
// Reset: counter, last level, last edge time and sticky flag clear; the
// channel is disabled and the width selects 32 bits.
`include "assert_macros.svh"
module debounced_edge_updown_counter_core import dbc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [0] pin_level, [32:1] time_ms, [39:33] zero
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [0] edge_counted, [1] wrapped, [65:2] count, [66] overflow_sticky, [71:67] zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t             cfg;
  result_t          res;

  logic             in_valid_q;
  logic             in_level_q;
  logic [TimeW-1:0] in_time_q;
  logic             out_valid_q;
  result_t          out_q;
  logic             advance;
  logic             take_in;

  // Move the held sample into the output register when that slot is free
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign take_in         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take_in) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_level_q <= s_axis_tdata_i[0];
      in_time_q  <= s_axis_tdata_i[TimeW:1];
    end
  end

  dbc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dbc_update u_update (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .step_i  (advance),
    .level_i (in_level_q),
    .time_i  (in_time_q),
    .res_o   (res)
  );

  // Hold the result word until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_q.overflow_sticky, out_q.count,
                            out_q.wrapped, out_q.edge_counted};

  `ASSERT_CLK(a_advance_shows, clk_i, rst_ni, advance |=> out_valid_q, "result word lost")
  `ASSERT_CLK(a_stall_keeps, clk_i, rst_ni,
              (in_valid_q && out_valid_q && !m_axis_tready_i) |=>
              (in_valid_q && $stable(in_time_q) && $stable(in_level_q)),
              "held sample lost during stall")
  `ASSERT_CLK(a_wrap_counted, clk_i, rst_ni,
              (out_valid_q && out_q.wrapped) |-> out_q.edge_counted,
              "wrap without counted edge")

endmodule
